### rtl/kc3_pkg.sv
// ----------------------------------------------------------------------------
// kc3_pkg
// Shared types and constants for the 3x3 kernel convolution block.
// ----------------------------------------------------------------------------
package kc3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int LS_AW       = $clog2(MAX_WIDTH);
    localparam int PIX_W       = 8;
    localparam int ROW_W       = 16;
    localparam int COL_W       = 10;
    localparam int IMG_W_W     = 11;
    localparam int ACC_W       = 20;
    localparam int MAG_W       = ACC_W - 1;
    localparam int TOT_W       = 12;
    localparam int DEN_W       = TOT_W - 1;
    localparam int PROD_W      = 17;
    localparam int DIV_STEPS   = MAG_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [IMG_W_W-1:0] MIN_DIM   = IMG_W_W'(3);
    localparam logic [IMG_W_W-1:0] MAX_W_LIM = IMG_W_W'(MAX_WIDTH);
    localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 3'd5;
    localparam int CFG_DATA_W = 24;

    typedef logic [2:0][PIX_W-1:0] coef_row_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             window_valid;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
    } result_t;

    // Effective configuration seen by front and back
    typedef struct packed {
        coef_row_t [2:0]    kernel;     // [0] top row, [c] column c (0 = left)
        logic               normalize;
        logic [IMG_W_W-1:0] width;      // clamped to 3..MAX_WIDTH
        logic [ROW_W-1:0]   height;     // raised to at least 3
    } cfg_t;

    // Window snapshot handed from front to back
    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] win;   // [row][col], row 0 oldest line
        logic                       valid;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
    } win_item_t;

endpackage

### rtl/kernel_convolution_3x3.sv
// ----------------------------------------------------------------------------
// kernel_convolution_3x3
// 3x3 convolution over a raster grayscale stream with two line stores.
// ----------------------------------------------------------------------------
// Each accepted pixel gives exactly one result beat, in order. The front
// reads the line store into a register when it accepts a pixel, then shifts
// the window and writes the store back before it takes the next pixel. The
// back stage sets the sustained rate for interior pixels: it loads a window,
// runs multiply-accumulate (one kernel row per cycle) and moves the clamped
// value into the result register once that is free; with normalize set and
// a nonzero coefficient total, the 19-step restoring divider runs before the
// result register. Border pixels skip the arithmetic. A two-entry queue
// between front and back absorbs short bursts, and the result register lets
// a finished beat wait while the next one is computed. The line stores start
// undefined; write pixel width changes only at a frame start.
// ----------------------------------------------------------------------------
module kernel_convolution_3x3 (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  kc3_pkg::item_t                     item,
    output logic                               empty,
    input  logic                               pop,
    output kc3_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kc3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kc3_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kc3_pkg::*;

    coef_row_t          kernel_top_reg;
    coef_row_t          kernel_mid_reg;
    coef_row_t          kernel_bot_reg;
    logic               normalize_reg;
    logic [IMG_W_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;

    cfg_t               cfg;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    win_item_t          q_data;
    win_item_t          q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_top_reg <= '0;
            kernel_mid_reg <= coef_row_t'(24'h000100);
            kernel_bot_reg <= '0;
            normalize_reg  <= 1'b0;
            width_reg      <= IMG_W_W'(640);
            height_reg     <= ROW_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KERNEL_TOP: kernel_top_reg <= cfg_data;
                CFG_KERNEL_MID: kernel_mid_reg <= cfg_data;
                CFG_KERNEL_BOT: kernel_bot_reg <= cfg_data;
                CFG_NORMALIZE:  normalize_reg  <= cfg_data[0];
                CFG_IMG_WIDTH:  width_reg      <= cfg_data[IMG_W_W-1:0];
                CFG_IMG_HEIGHT: height_reg     <= cfg_data[ROW_W-1:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Effective dimensions: clamp width to 3..MAX_WIDTH, raise height to 3
    always_comb
    begin
        cfg.kernel[0] = kernel_top_reg;
        cfg.kernel[1] = kernel_mid_reg;
        cfg.kernel[2] = kernel_bot_reg;
        cfg.normalize = normalize_reg;
        if (width_reg < MIN_DIM)
        begin
            cfg.width = MIN_DIM;
        end
        else if (width_reg > MAX_W_LIM)
        begin
            cfg.width = MAX_W_LIM;
        end
        else
        begin
            cfg.width = width_reg;
        end
        cfg.height = (height_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : height_reg;
    end

    kc3_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    kc3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .q_full    (q_full),
        .pop       (q_pop),
        .q_empty   (q_empty),
        .head      (q_head)
    );

    kc3_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .head    (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

### rtl/kc3_queue.sv
// ----------------------------------------------------------------------------
// kc3_queue
// Short queue of window snapshots between the front and back stages.
// ----------------------------------------------------------------------------
module kc3_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kc3_pkg::win_item_t push_data,
    output logic              q_full,
    input  logic              pop,
    output logic              q_empty,
    output kc3_pkg::win_item_t head
);
    import kc3_pkg::*;

    win_item_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_AW:0]      count_reg;

    assign q_full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/kc3_front.sv
// ----------------------------------------------------------------------------
// kc3_front
// Accepts pixels, tracks raster position, keeps the line stores and the 3x3
// window, and classifies each pixel as an interior window or a border beat.
// ----------------------------------------------------------------------------
module kc3_front (
    input  logic               clk,
    input  logic               rst_n,
    input  kc3_pkg::cfg_t      cfg,
    input  logic               push,
    input  kc3_pkg::item_t     item,
    output logic               full,
    input  logic               q_full,
    output logic               q_push,
    output kc3_pkg::win_item_t q_data
);
    import kc3_pkg::*;

    typedef enum logic {
        F_IDLE,
        F_WORK
    } fstate_t;

    fstate_t                    state_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [COL_W-1:0]           col_reg;
    logic [ROW_W-1:0]           cur_row_reg;
    logic [COL_W-1:0]           cur_col_reg;
    logic [PIX_W-1:0]           px_reg;
    logic [2:0][2:0][PIX_W-1:0] win_reg;
    logic [2*PIX_W-1:0]         ls_mem [MAX_WIDTH];   // {older, prev} per column
    logic [2*PIX_W-1:0]         rd_data_reg;

    logic                       accept;
    logic [COL_W-1:0]           col_start;
    logic [ROW_W:0]             row_start;
    logic [COL_W-1:0]           col_adj;
    logic [ROW_W:0]             row_bump;
    logic [ROW_W-1:0]           row_adj;
    logic [2:0][2:0][PIX_W-1:0] win_next;
    logic                       win_ok;
    logic [IMG_W_W-1:0]         col_inc;
    logic [ROW_W:0]             row_inc;

    assign full   = !((state_reg == F_IDLE) && !q_full);
    assign accept = push && !full;

    // Position of the incoming pixel: frame start, then late row and frame wraps
    always_comb
    begin
        col_start = item.frame_start ? '0 : col_reg;
        row_start = item.frame_start ? '0 : {1'b0, row_reg};
        if ({1'b0, col_start} >= cfg.width)
        begin
            col_adj  = '0;
            row_bump = row_start + 1'b1;
        end
        else
        begin
            col_adj  = col_start;
            row_bump = row_start;
        end
        if (row_bump >= {1'b0, cfg.height})
        begin
            row_adj = '0;
        end
        else
        begin
            row_adj = row_bump[ROW_W-1:0];
        end
    end

    // Shift the window left and bring in the new column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = rd_data_reg[2*PIX_W-1:PIX_W];
        win_next[1][2] = rd_data_reg[PIX_W-1:0];
        win_next[2][2] = px_reg;
    end

    assign win_ok  = (cur_row_reg >= ROW_W'(2)) && (cur_col_reg >= COL_W'(2));
    assign col_inc = {1'b0, cur_col_reg} + 1'b1;
    assign row_inc = {1'b0, cur_row_reg} + 1'b1;

    assign q_push       = (state_reg == F_WORK);
    assign q_data.win   = win_next;
    assign q_data.valid = win_ok;
    assign q_data.row   = win_ok ? cur_row_reg - 1'b1 : '0;
    assign q_data.col   = win_ok ? cur_col_reg - 1'b1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            win_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        cur_row_reg <= row_adj;
                        cur_col_reg <= col_adj;
                        px_reg      <= item.pixel;
                        state_reg   <= F_WORK;
                    end
                end
                F_WORK:
                begin
                    win_reg <= win_next;
                    if (col_inc >= cfg.width)
                    begin
                        col_reg <= '0;
                        row_reg <= (row_inc >= {1'b0, cfg.height}) ? '0
                                                                   : row_inc[ROW_W-1:0];
                    end
                    else
                    begin
                        col_reg <= col_inc[COL_W-1:0];
                        row_reg <= cur_row_reg;
                    end
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Line store: read at accept, write back in the following cycle at the same column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= ls_mem[col_adj[LS_AW-1:0]];
        end
        if (state_reg == F_WORK)
        begin
            ls_mem[cur_col_reg[LS_AW-1:0]] <= {rd_data_reg[PIX_W-1:0], px_reg};
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

endmodule

### rtl/kc3_back.sv
// ----------------------------------------------------------------------------
// kc3_back
// Weighted sum of a window, optional division by the coefficient total,
// clamping, and the result register facing the consumer.
// ----------------------------------------------------------------------------
module kc3_back (
    input  logic               clk,
    input  logic               rst_n,
    input  kc3_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  kc3_pkg::win_item_t head,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output kc3_pkg::result_t   result
);
    import kc3_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MAC,
        B_DIV,
        B_DONE
    } bstate_t;

    bstate_t                 state_reg;
    win_item_t               cur_reg;
    logic [1:0]              row_sel_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [TOT_W-1:0] tot_reg;
    logic [MAG_W-1:0]        mag_reg;     // magnitude, then quotient
    logic                    neg_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    result_t                 out_reg;
    logic                    out_full_reg;

    logic signed [TOT_W-1:0]  tot_next;
    logic signed [PROD_W-1:0] prod [3];
    logic signed [ACC_W-1:0]  row_sum;
    logic signed [ACC_W-1:0]  acc_fin;
    logic signed [ACC_W-1:0]  acc_abs;
    logic signed [TOT_W-1:0]  tot_abs;
    logic [DEN_W:0]           rem_shift;
    logic                     q_bit;
    logic [DEN_W-1:0]         rem_next;
    logic [PIX_W-1:0]         clamped;

    assign q_pop  = (state_reg == B_IDLE) && !q_empty;
    assign empty  = !out_full_reg;
    assign result = out_reg;

    always_comb
    begin
        tot_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                tot_next = tot_next + TOT_W'($signed(cfg.kernel[r][c]));
            end
        end
    end

    // One kernel row per cycle
    always_comb
    begin
        row_sum = '0;
        for (int c = 0; c < 3; c++)
        begin
            prod[c] = $signed({1'b0, cur_reg.win[row_sel_reg][c]})
                      * $signed(cfg.kernel[row_sel_reg][c]);
            row_sum = row_sum + ACC_W'(prod[c]);
        end
        acc_fin = acc_reg + row_sum;
        acc_abs = acc_fin[ACC_W-1] ? -acc_fin : acc_fin;
        tot_abs = tot_reg[TOT_W-1] ? -tot_reg : tot_reg;
    end

    // Restoring divide step: one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, mag_reg[MAG_W-1]};
        q_bit     = (rem_shift >= {1'b0, den_reg});
        rem_next  = q_bit ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
    end

    always_comb
    begin
        if (!cur_reg.valid || (neg_reg && (mag_reg != '0)))
        begin
            clamped = '0;
        end
        else if (mag_reg > MAG_W'(PIX_MAX))
        begin
            clamped = PIX_MAX;
        end
        else
        begin
            clamped = mag_reg[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_full_reg)
            begin
                out_full_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_reg     <= head;
                        tot_reg     <= tot_next;
                        acc_reg     <= '0;
                        row_sel_reg <= '0;
                        state_reg   <= head.valid ? B_MAC : B_DONE;
                    end
                end
                B_MAC:
                begin
                    acc_reg     <= acc_fin;
                    row_sel_reg <= row_sel_reg + 1'b1;
                    if (row_sel_reg == 2'd2)
                    begin
                        mag_reg <= acc_abs[MAG_W-1:0];
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        den_reg <= tot_abs[DEN_W-1:0];
                        if (cfg.normalize && (tot_reg != '0))
                        begin
                            neg_reg   <= acc_fin[ACC_W-1] ^ tot_reg[TOT_W-1];
                            state_reg <= B_DIV;
                        end
                        else
                        begin
                            neg_reg   <= acc_fin[ACC_W-1];
                            state_reg <= B_DONE;
                        end
                    end
                end
                B_DIV:
                begin
                    rem_reg <= rem_next;
                    mag_reg <= {mag_reg[MAG_W-2:0], q_bit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (!out_full_reg)
                    begin
                        out_reg.value        <= clamped;
                        out_reg.window_valid <= cur_reg.valid;
                        out_reg.center_row   <= cur_reg.row;
                        out_reg.center_col   <= cur_reg.col;
                        out_full_reg         <= 1'b1;
                        state_reg            <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !out_reg.window_valid) |->
            (out_reg.value == '0) && (out_reg.center_row == '0)
            && (out_reg.center_col == '0))
        else $error("border beat carries nonzero fields");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (cnt_reg < DIV_CNT_W'(DIV_STEPS)) && (den_reg != '0))
        else $error("divider step count or divisor out of range");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !pop) |=> out_full_reg && $stable(out_reg))
        else $error("waiting result changed before pop");

endmodule
